// ----- rtl/gaq_pkg.sv -----
// shared types and constants for the gas alarm qualifier
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package gaq_pkg;

  localparam logic [1:0] LEVEL_SAFE    = 2'd0;
  localparam logic [1:0] LEVEL_DANGER  = 2'd1;
  localparam logic [1:0] LEVEL_WARMING = 2'd2;

  localparam logic [1:0] REG_ACTIVE_LOW      = 2'd0;
  localparam logic [1:0] REG_SAMPLE_INTERVAL = 2'd1;
  localparam logic [1:0] REG_WARMUP_TIME     = 2'd2;
  localparam logic [1:0] REG_QUIET_NEEDED    = 2'd3;

  localparam logic [15:0] AGE_MAX    = 16'hFFFF;
  localparam logic [31:0] ELAPSED_MAX = 32'hFFFF_FFFF;
  localparam logic [7:0]  STREAK_MAX = 8'hFF;

  // sampling decision from the tick timer
  typedef struct packed {
    logic        sample;
    logic [31:0] left;
  } sample_info_t;

  // one result transaction
  typedef struct packed {
    logic        detected;
    logic [1:0]  level;
    logic        valid_res;
    logic [31:0] warmup_left;
  } result_t;

endpackage

// ----- rtl/gaq_timer.sv -----
// tick timer: elapsed and sample-age counters, sample decision, warm-up remaining
// depends on gaq_pkg
`timescale 1ns / 1ps

module gaq_timer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick,
  input  logic [15:0]           sample_interval,
  input  logic [31:0]           warmup_time,
  output gaq_pkg::sample_info_t info
);
  import gaq_pkg::*;

  logic [31:0] ticks_since_start;
  logic [15:0] ticks_since_sample;
  logic [15:0] age;

  assign age = (ticks_since_sample != AGE_MAX) ? ticks_since_sample + 16'd1 : AGE_MAX;

  always_comb begin
    info.sample = (age >= sample_interval);
    info.left   = (ticks_since_start >= warmup_time) ? 32'd0
                                                     : warmup_time - ticks_since_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_since_start  <= 32'd0;
      ticks_since_sample <= AGE_MAX;
    end else if (tick) begin
      if (ticks_since_start != ELAPSED_MAX) begin
        ticks_since_start <= ticks_since_start + 32'd1;
      end
      ticks_since_sample <= info.sample ? 16'd0 : age;
    end
  end

endmodule

// ----- rtl/gaq_debounce.sv -----
// asymmetric debounce: immediate raise, clear after a run of quiet samples
// depends on gaq_pkg
`timescale 1ns / 1ps

module gaq_debounce (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick,
  input  gaq_pkg::sample_info_t info,
  input  logic                  pin_level,
  input  logic                  active_low,
  input  logic [7:0]            quiet_needed,
  output gaq_pkg::result_t      result
);
  import gaq_pkg::*;

  logic       alarm_raised, alarm_raised_next;
  logic [7:0] quiet_streak, quiet_streak_next;
  logic [7:0] streak_inc;
  logic       tripped;

  assign tripped    = active_low ? ~pin_level : pin_level;
  assign streak_inc = (quiet_streak != STREAK_MAX) ? quiet_streak + 8'd1 : STREAK_MAX;

  always_comb begin
    alarm_raised_next = alarm_raised;
    quiet_streak_next = quiet_streak;
    if (info.left != 32'd0) begin
      alarm_raised_next = 1'b0;
      quiet_streak_next = 8'd0;
    end else if (tripped) begin
      alarm_raised_next = 1'b1;
      quiet_streak_next = 8'd0;
    end else if (alarm_raised) begin
      if (streak_inc >= quiet_needed) begin
        alarm_raised_next = 1'b0;
        quiet_streak_next = 8'd0;
      end else begin
        quiet_streak_next = streak_inc;
      end
    end

    if (info.left != 32'd0) begin
      result.detected    = 1'b0;
      result.level       = LEVEL_WARMING;
      result.valid_res   = 1'b0;
      result.warmup_left = info.left;
    end else begin
      result.detected    = alarm_raised_next;
      result.level       = alarm_raised_next ? LEVEL_DANGER : LEVEL_SAFE;
      result.valid_res   = 1'b1;
      result.warmup_left = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_raised <= 1'b0;
      quiet_streak <= 8'd0;
    end else if (tick && info.sample) begin
      alarm_raised <= alarm_raised_next;
      quiet_streak <= quiet_streak_next;
    end
  end

endmodule

// ----- rtl/gaq_out_buf.sv -----
// result register with a skid entry behind it
// depends on gaq_pkg
`timescale 1ns / 1ps

module gaq_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gaq_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output gaq_pkg::result_t out_data
);
  import gaq_pkg::*;

  logic    head_valid, skid_valid;
  result_t head, skid;
  logic    pop;

  assign pop       = head_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = head_valid;
  assign out_data  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!head_valid || pop) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!head_valid || pop) begin
      head <= skid_valid ? skid : push_data;
    end else if (push) begin
      skid <= push_data;
    end
  end

endmodule

// ----- rtl/gas_alarm_qualifier.sv -----
// top level of the gas alarm qualifier: config registers, timer, debounce, output buffer
// depends on gaq_pkg, gaq_timer, gaq_debounce, gaq_out_buf
`timescale 1ns / 1ps

// usage
//   input channel: one transaction per millisecond tick, carrying pin_level;
//   accepted when in_valid is high and in_stall is low
//   a tick that takes a sample yields one result transaction (detected, level,
//   valid_res, warmup_left); other ticks yield none
//   output channel: result offered with out_valid, taken when out_stall is low
//   result: registered into the result register, or into the skid entry if that is occupied
//   throughput: one tick per cycle while in_stall is low; all work for a tick
//   is one pass through the counter compares and the debounce update
//   stall: a result register plus one skid entry absorb a stalled receiver;
//   in_stall rises only while the skid entry holds a result
//   config port: cfg_ready is always high; index 0 active_low, 1 sample_interval,
//   2 warmup_time, 3 quiet_needed (a zero is stored as one); write only while idle
//   reset: rst synchronous active high; registers return to their defaults,
//   the first tick after reset samples, alarm and streak clear, buffer empties

module gas_alarm_qualifier (
  input  logic        clk,
  input  logic        rst,
  // tick channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        pin_level,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        detected,
  output logic [1:0]  level,
  output logic        valid_res,
  output logic [31:0] warmup_left,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import gaq_pkg::*;

  // configuration registers
  logic        active_low;
  logic [15:0] sample_interval;
  logic [31:0] warmup_time;
  logic [7:0]  quiet_needed;

  logic         tick;
  sample_info_t info;
  result_t      result;
  result_t      out_data;
  logic         buf_full;

  assign cfg_ready = 1'b1;
  assign tick      = in_valid && !in_stall;
  assign in_stall  = buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_low      <= 1'b1;
      sample_interval <= 16'd1000;
      warmup_time     <= 32'd60000;
      quiet_needed    <= 8'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACTIVE_LOW:      active_low      <= cfg_data[0];
        REG_SAMPLE_INTERVAL: sample_interval <= cfg_data[15:0];
        REG_WARMUP_TIME:     warmup_time     <= cfg_data;
        REG_QUIET_NEEDED:    quiet_needed    <= (cfg_data[7:0] == 8'd0) ? 8'd1
                                                                        : cfg_data[7:0];
      endcase
    end
  end

  // sample timing and warm-up remaining
  gaq_timer u_timer (
    .clk             (clk),
    .rst             (rst),
    .tick            (tick),
    .sample_interval (sample_interval),
    .warmup_time     (warmup_time),
    .info            (info)
  );

  // alarm state and verdict for a sampling tick
  gaq_debounce u_debounce (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick),
    .info         (info),
    .pin_level    (pin_level),
    .active_low   (active_low),
    .quiet_needed (quiet_needed),
    .result       (result)
  );

  // only sampling ticks push a result
  gaq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (tick && info.sample),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign detected    = out_data.detected;
  assign level       = out_data.level;
  assign valid_res   = out_data.valid_res;
  assign warmup_left = out_data.warmup_left;

`ifndef SYNTHESIS
  // skid entry only fills behind an occupied result register
  a_stall_has_head: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid entry full while result register empty");

  // a valid verdict reports no warm-up left
  a_valid_no_warmup: assert property (@(posedge clk) disable iff (rst)
    (out_valid && valid_res) |-> (warmup_left == 32'd0 && level != LEVEL_WARMING))
    else $error("valid verdict with warm-up remaining");

  // withheld verdicts are warming up with no alarm and time still left
  a_warming_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |->
      (level == LEVEL_WARMING && !detected && warmup_left != 32'd0))
    else $error("malformed warming-up result");

  // detected flag agrees with danger level
  a_detect_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (detected == (level == LEVEL_DANGER)))
    else $error("detected and level disagree");
`endif

endmodule

// ----- bench/gaq_verdict_board_pkg.sv -----
// alarm verdict predictor and result checker for the gas alarm qualifier bench
// depends on gaq_pkg for the level codes, saturation limits and result_t
`timescale 1ns / 1ps

package gaq_verdict_board_pkg;

  import gaq_pkg::*;

  class verdict_board;
    // register copies
    bit        act_low;
    bit [15:0] interval;
    bit [31:0] warm_time;
    bit [7:0]  quiet_need;
    // timer and debounce state
    bit [31:0] elapsed_ctr;
    bit [15:0] since_sample;
    bit        alarm;
    bit [7:0]  streak;
    result_t   due_verdicts[$];
    int        errors;

    function new();
      act_low      = 1'b1;
      interval     = 16'd1000;
      warm_time    = 32'd60000;
      quiet_need   = 8'd3;
      elapsed_ctr  = '0;
      since_sample = AGE_MAX;
      alarm        = 1'b0;
      streak       = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_ACTIVE_LOW:      act_low = data[0];
        REG_SAMPLE_INTERVAL: interval = data[15:0];
        REG_WARMUP_TIME:     warm_time = data;
        REG_QUIET_NEEDED:    quiet_need = (data[7:0] == 8'd0) ? 8'd1 : data[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_verdicts.size();
    endfunction

    // one accepted tick: advance the timers and queue a verdict when it samples
    function void predict_tick(logic pin);
      bit [31:0] now_t;
      bit [31:0] left;
      bit [15:0] age;
      bit        trip;
      result_t   r;
      now_t = elapsed_ctr;
      age = since_sample;
      if (age != AGE_MAX) age++;
      if (elapsed_ctr != ELAPSED_MAX) elapsed_ctr++;
      if (age < interval) begin
        since_sample = age;
        return;
      end
      since_sample = '0;
      left = (now_t >= warm_time) ? 32'd0 : warm_time - now_t;
      if (left != 32'd0) begin
        alarm = 1'b0;
        streak = '0;
        r.detected = 1'b0;
        r.level = LEVEL_WARMING;
        r.valid_res = 1'b0;
        r.warmup_left = left;
      end else begin
        trip = act_low ? (pin == 1'b0) : (pin == 1'b1);
        if (trip) begin
          alarm = 1'b1;
          streak = '0;
        end else if (alarm) begin
          if (streak != STREAK_MAX) streak++;
          if (streak >= quiet_need) begin
            alarm = 1'b0;
            streak = '0;
          end
        end
        r.detected = alarm;
        r.level = alarm ? LEVEL_DANGER : LEVEL_SAFE;
        r.valid_res = 1'b1;
        r.warmup_left = '0;
      end
      due_verdicts.push_back(r);
    endfunction

    function void check_verdict(result_t got);
      result_t want;
      if (due_verdicts.size() == 0) begin
        $display("%0t: result transaction with nothing expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = due_verdicts.pop_front();
      if (got.detected !== want.detected) begin
        $display("%0t: detected expected %0b actual %0b", $time, want.detected, got.detected);
        errors++;
      end
      if (got.level !== want.level) begin
        $display("%0t: level expected %0d actual %0d", $time, want.level, got.level);
        errors++;
      end
      if (got.valid_res !== want.valid_res) begin
        $display("%0t: valid_res expected %0b actual %0b", $time, want.valid_res,
                 got.valid_res);
        errors++;
      end
      if (got.warmup_left !== want.warmup_left) begin
        $display("%0t: warmup_left expected %0d actual %0d", $time, want.warmup_left,
                 got.warmup_left);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- bench/gas_alarm_qualifier_test.sv -----
// self-checking bench for gas_alarm_qualifier: directed ticks, then random phases
// depends on gaq_pkg, gaq_verdict_board_pkg and the gas_alarm_qualifier rtl
`timescale 1ns / 1ps

module gas_alarm_qualifier_test;

  import gaq_pkg::*;
  import gaq_verdict_board_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        pin_level;
  logic        out_valid;
  logic        out_stall;
  logic        detected;
  logic [1:0]  level;
  logic        valid_res;
  logic [31:0] warmup_left;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  verdict_board sb = new();

  // set by stimulus: the receiver holds off for a long stretch
  bit hold_req;
  // last part of the run: no idling on either side
  bit tail;
  int ticks_sent;

  gas_alarm_qualifier u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pin_level   (pin_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .detected    (detected),
    .level       (level),
    .valid_res   (valid_res),
    .warmup_left (warmup_left),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // send n ticks of one pin level, with random idle bursts between transactions;
  // valid stays high from one tick to the next unless a burst lowers it
  task automatic send_ticks(input logic pin, input int n);
    for (int i = 0; i < n; i++) begin
      in_valid <= 1'b1;
      pin_level <= pin;
      // values read right after the edge are the ones the block saw at it
      do @(posedge clk); while (in_stall);
      sb.predict_tick(pin);
      ticks_sent++;
      if (!tail && $urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  endtask

  // pause the ticks until every verdict is out, then let the block settle
  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all four registers; raw words, so upper bits may carry junk
  task automatic load_settings(input logic [31:0] al, input logic [31:0] iv,
                               input logic [31:0] warm, input logic [31:0] quiet);
    logic [31:0] vals[4];
    vals[REG_ACTIVE_LOW] = al;
    vals[REG_SAMPLE_INTERVAL] = iv;
    vals[REG_WARMUP_TIME] = warm;
    vals[REG_QUIET_NEEDED] = quiet;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(2'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // result monitor: a transaction moves when out_valid is high and out_stall low
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_verdict({detected, level, valid_res, warmup_left});
    end
  end

  // receiver side: random stall bursts, open stretches, and one long hold-off
  initial begin
    out_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        // long hold-off counted here so the block fills and stalls its input
        out_stall <= 1'b1;
        repeat (40) @(posedge clk);
        hold_req = 1'b0;
      end else if (!tail && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // watchdog, far above the slowest correct run
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // main stimulus
  initial begin
    int   n_left;
    int   len;
    int   sel;
    logic p;
    logic trip_pin;
    bit   want_trip;
    logic [31:0] al_w;
    logic [31:0] iv_w;
    logic [31:0] warm_w;
    logic [31:0] quiet_w;

    rst <= 1'b1;
    in_valid <= 1'b0;
    pin_level <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ACTIVE_LOW;
    cfg_data <= '0;
    hold_req = 1'b0;
    tail = 1'b0;
    ticks_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: the first tick samples and reports warming up
    send_ticks(1'b0, 1);
    send_ticks(1'b1, 1);
    wait_for_verdicts();

    // no warm-up, every tick samples, zero quiet count stored as one
    load_settings(32'd1, 32'd0, 32'd0, 32'd0);
    send_ticks(1'b0, 1);
    send_ticks(1'b1, 2);
    send_ticks(1'b0, 2);
    wait_for_verdicts();

    // high level trips; junk upper bits in the words must be ignored
    load_settings(32'hFFFF_FFFE, 32'h0001_0000, 32'd0, 32'hA5A5_0003);
    send_ticks(1'b1, 1);
    send_ticks(1'b0, 2);
    send_ticks(1'b1, 1);
    send_ticks(1'b0, 3);
    wait_for_verdicts();

    // largest warm-up: warm-up reopens long after it ended
    load_settings(32'd1, 32'd0, 32'hFFFF_FFFF, 32'd255);
    send_ticks(1'b0, 1);
    send_ticks(1'b1, 1);
    wait_for_verdicts();

    // warm-up counting down through its last ticks into valid verdicts
    load_settings(32'd1, 32'd0, sb.elapsed_ctr + 32'd2, 32'd1);
    send_ticks(1'b0, 3);
    send_ticks(1'b1, 1);
    wait_for_verdicts();

    // largest interval: ticks that take no sample
    load_settings(32'd1, 32'hFFFF, 32'd0, 32'd3);
    send_ticks(1'b0, 2);
    wait_for_verdicts();

    // random phases with well-formed alarm and quiet runs plus noise
    for (int ph = 0; ticks_sent < 850; ph++) begin
      if (ticks_sent >= 700) tail = 1'b1;
      if (ph == 2) begin
        // longest quiet count: clears on exactly the 255th quiet sample
        load_settings(32'd1, 32'd0, 32'd0, 32'd255);
        send_ticks(1'b0, 2);
        send_ticks(1'b1, 255);
        send_ticks(1'b0, 1);
        send_ticks(1'b1, 20);
      end else begin
        al_w = ($urandom & 32'hFFFF_FFFE) | 32'($urandom_range(0, 1));
        sel = $urandom_range(0, 9);
        iv_w = {16'($urandom), 16'((sel < 4 || ph == 1) ? 0 : $urandom_range(1, 6))};
        sel = $urandom_range(0, 9);
        if (sel < 3) warm_w = 32'd0;
        else if (sel < 9) warm_w = sb.elapsed_ctr + 32'($urandom_range(0, 30));
        else warm_w = $urandom;
        quiet_w = {24'($urandom), 8'($urandom_range(0, 6))};
        load_settings(al_w, iv_w, warm_w, quiet_w);
        // every tick samples here, so a long receiver hold-off backs up the input
        if (ph == 1) hold_req = 1'b1;
        trip_pin = sb.act_low ? 1'b0 : 1'b1;
        want_trip = 1'b1;
        n_left = $urandom_range(40, 120);
        while (n_left > 0) begin
          if ($urandom_range(0, 4) == 0) begin
            p = 1'($urandom_range(0, 1));
            len = 1;
          end else if (want_trip) begin
            p = trip_pin;
            len = $urandom_range(1, 3) * (int'(sb.interval) + 1);
            want_trip = 1'b0;
          end else begin
            p = !trip_pin;
            len = $urandom_range(1, int'(sb.quiet_need) + 2) * (int'(sb.interval) + 1);
            want_trip = 1'b1;
          end
          send_ticks(p, len);
          n_left -= len;
        end
      end
      wait_for_verdicts();
    end

    // catch any stray result after the last verdict
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
